FILE: rtl/aprc_pkg.sv
`default_nettype none
package aprc_pkg;
   localparam int FRAMES    = 16;
   localparam int AGE_BITS  = 3;
   localparam int FRAME_IDS = 16;
   localparam int PID_W     = 16;
   localparam int FRAME_W   = 4;
   localparam int IDX_W     = $clog2(FRAMES);
   localparam int CNT_W     = $clog2(FRAMES + 1);

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_REFER   = 2'd1,
      OP_REPLACE = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic wrap;
   } cell_ctl_type;
endpackage
`default_nettype wire

FILE: rtl/aprc_cell.sv
`default_nettype none
module aprc_cell (
   input  wire                         clock,
   input  wire aprc_pkg::cell_ctl_type ctl,
   input  wire [aprc_pkg::PID_W-1:0]   load_pid,
   input  wire [aprc_pkg::FRAME_W-1:0] load_frame,
   input  wire [aprc_pkg::PID_W-1:0]   next_pid,
   input  wire [aprc_pkg::FRAME_W-1:0] next_frame,
   input  wire [aprc_pkg::PID_W-1:0]   head_pid,
   input  wire [aprc_pkg::FRAME_W-1:0] head_frame,
   output logic [aprc_pkg::PID_W-1:0]   pid,
   output logic [aprc_pkg::FRAME_W-1:0] frame
);
   import aprc_pkg::*;

   logic [PID_W-1:0]   pid_ff;
   logic [FRAME_W-1:0] frame_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pid_ff   <= load_pid;
         frame_ff <= load_frame;
      end else if (ctl.shift) begin
         pid_ff   <= ctl.wrap ? head_pid : next_pid;
         frame_ff <= ctl.wrap ? head_frame : next_frame;
      end
   end

   assign pid   = pid_ff;
   assign frame = frame_ff;
endmodule
`default_nettype wire

FILE: rtl/aging_page_replacement.sv
`default_nettype none
// Aging page replacement: resident (pid, frame) entries sit in a row of cells in
// list order, head first. Insert, reference and no-op transactions answer in the
// cycle after acceptance. A replace rotates the row once through all N resident
// entries, aging one entry per cycle at the head cell, then rotates on until the
// victim at offset m has passed the head and drops off the end of the row; it
// answers when that rotation ends, and new requests stall until then.
module aging_page_replacement (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire [1:0]                   req_op,
   input  wire [aprc_pkg::PID_W-1:0]   req_owner_pid,
   input  wire [aprc_pkg::FRAME_W-1:0] req_frame_number,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [aprc_pkg::PID_W-1:0]   rsp_victim_pid,
   output logic [aprc_pkg::FRAME_W-1:0] rsp_victim_frame,
   output logic [1:0]                   rsp_status
);
   import aprc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_ROT} state_type;

   state_type            state_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     walk_ff;
   logic [CNT_W-1:0]     rot_ff;
   logic [IDX_W-1:0]     min_idx_ff;
   logic [AGE_BITS-1:0]  min_age_ff;
   logic [FRAME_W-1:0]   min_frame_ff;
   logic [PID_W-1:0]     min_pid_ff;
   logic [AGE_BITS-1:0]  age_ff [FRAME_IDS];
   logic                 ref_ff [FRAME_IDS];
   logic                 rsp_valid_ff;
   logic [PID_W-1:0]     rsp_pid_ff;
   logic [FRAME_W-1:0]   rsp_frame_ff;
   logic [1:0]           rsp_status_ff;

   logic [PID_W-1:0]     cell_pid   [FRAMES];
   logic [FRAME_W-1:0]   cell_frame [FRAMES];
   logic [PID_W-1:0]     next_pid   [FRAMES];
   logic [FRAME_W-1:0]   next_frame [FRAMES];
   cell_ctl_type         ctl        [FRAMES];

   logic                 req_accept;
   logic [CNT_W-1:0]     last_in;
   logic [FRAME_W-1:0]   cur_frame;
   logic [AGE_BITS-1:0]  new_age_in;
   logic                 take_in;
   logic                 same_in;
   logic [IDX_W-1:0]     min_idx_in;

   assign req_stall  = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign last_in    = count_ff - CNT_W'(1);
   assign cur_frame  = cell_frame[0];
   assign new_age_in = {ref_ff[cur_frame], age_ff[cur_frame][AGE_BITS-1:1]};
   assign same_in    = (cur_frame == min_frame_ff);
   assign take_in    = (walk_ff == '0) || (!same_in && (new_age_in < min_age_ff));
   assign min_idx_in = take_in ? walk_ff[IDX_W-1:0] : min_idx_ff;

   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         if (i < FRAMES - 1) begin
            next_pid[i]   = cell_pid[i+1];
            next_frame[i] = cell_frame[i+1];
         end else begin
            next_pid[i]   = cell_pid[0];
            next_frame[i] = cell_frame[0];
         end
         ctl[i].load  = req_accept && (op_type'(req_op) == OP_INSERT)
                        && (count_ff == CNT_W'(i));
         ctl[i].shift = (state_ff != S_IDLE);
         ctl[i].wrap  = (last_in == CNT_W'(i));
      end
   end

   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      aprc_cell u_cell (
         .clock      (clock),
         .ctl        (ctl[g]),
         .load_pid   (req_owner_pid),
         .load_frame (req_frame_number),
         .next_pid   (next_pid[g]),
         .next_frame (next_frame[g]),
         .head_pid   (cell_pid[0]),
         .head_frame (cell_frame[0]),
         .pid        (cell_pid[g]),
         .frame      (cell_frame[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FRAME_IDS; i++) begin
            age_ff[i] <= '0;
            ref_ff[i] <= 1'b0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_pid_ff    <= '0;
                  rsp_frame_ff  <= '0;
                  rsp_status_ff <= ST_DONE;
                  case (op_type'(req_op))
                     OP_INSERT: begin
                        if (count_ff == CNT_W'(FRAMES)) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           count_ff                 <= count_ff + CNT_W'(1);
                           age_ff[req_frame_number] <= '0;
                           ref_ff[req_frame_number] <= 1'b0;
                        end
                     end
                     OP_REFER: ref_ff[req_frame_number] <= 1'b1;
                     OP_REPLACE: begin
                        if (count_ff == '0) begin
                           rsp_status_ff <= ST_EMPTY;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= S_WALK;
                           walk_ff      <= '0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_WALK: begin
               age_ff[cur_frame] <= new_age_in;
               ref_ff[cur_frame] <= 1'b0;
               if (take_in || same_in) min_age_ff <= new_age_in;
               if (take_in) begin
                  min_frame_ff <= cur_frame;
                  min_pid_ff   <= cell_pid[0];
               end
               min_idx_ff <= min_idx_in;
               walk_ff    <= walk_ff + CNT_W'(1);
               if (walk_ff == last_in) begin
                  state_ff <= S_ROT;
                  rot_ff   <= CNT_W'(min_idx_in) + CNT_W'(1);
               end
            end
            S_ROT: begin
               rot_ff <= rot_ff - CNT_W'(1);
               if (rot_ff == CNT_W'(1)) begin
                  state_ff      <= S_IDLE;
                  count_ff      <= last_in;
                  rsp_valid_ff  <= 1'b1;
                  rsp_pid_ff    <= min_pid_ff;
                  rsp_frame_ff  <= min_frame_ff;
                  rsp_status_ff <= ST_DONE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_victim_pid   = rsp_pid_ff;
   assign rsp_victim_frame = rsp_frame_ff;
   assign rsp_status       = rsp_status_ff;
endmodule
`default_nettype wire
